// ===== hw/rtl/pfam_pkg.sv =====
// ----------------------------------------------------------------------------
// pfam_pkg
// Shared types and constants of the page frame allocator and mapper.
// ----------------------------------------------------------------------------
package pfam_pkg;

  // Sizes of the frame pool and the page directories
  localparam int FRAME_COUNT     = 32;
  localparam int DIR_COUNT       = 4;
  localparam int FRAME_SIZE_LOG2 = 22;
  localparam int ENTRIES_PER_DIR = 1024;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int DIR_W    = 2;
  localparam int PAGE_W   = 10;
  localparam int AMOUNT_W = 32;
  localparam int FRAME_W  = 5;
  localparam int COUNT_W  = 6;
  localparam int ENTRY_W  = 14;
  localparam int PFN_W    = 10;
  localparam int FLAGS_W  = 4;
  localparam int AVAIL_W  = COUNT_W + FRAME_SIZE_LOG2;
  localparam int CMP_W    = AMOUNT_W + AVAIL_W;

  // Directory entry store
  localparam int MEM_DEPTH = DIR_COUNT * ENTRIES_PER_DIR;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Lowest-free search: groups of frames, one encoder each
  localparam int GROUP_W     = 8;
  localparam int GROUP_COUNT = FRAME_COUNT / GROUP_W;
  localparam int IN_GROUP_W  = $clog2(GROUP_W);
  localparam int GROUP_SEL_W = $clog2(GROUP_COUNT);

  // Entry layout: flags in the low bits, frame number above
  localparam logic [FLAGS_W-1:0] PTE_PRESENT = 4'b0001;
  localparam logic [FLAGS_W-1:0] PTE_WRITE   = 4'b0010;
  localparam logic [FLAGS_W-1:0] PTE_USER    = 4'b0100;
  localparam logic [FLAGS_W-1:0] PTE_BIG     = 4'b1000;

  localparam logic [PAGE_W-1:0]  KERNEL_HIGH_INDEX = 10'h300;
  localparam logic [ENTRY_W-1:0] KERNEL_ENTRY =
    {{PFN_W{1'b0}}, PTE_BIG | PTE_WRITE | PTE_PRESENT};

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_CHECK = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  // Request and result payloads
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DIR_W-1:0]    dir_id;
    logic [PAGE_W-1:0]   virtual_page;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] free_frames;
    logic               flush_valid;
    logic [PAGE_W-1:0]  flush_page;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic load_en;
    logic scan_en;
    logic commit_en;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } dp_status_t;

endpackage

// ===== hw/rtl/pfam_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfam_ctrl
// Sequencer: clearing pass after reset, then accept, look up, commit.
// ----------------------------------------------------------------------------
module pfam_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pfam_pkg::dp_status_t status_i,
  output pfam_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOK   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.scan_en = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold until the result register is free
        if (!status_i.out_stall) begin
          cmd_o.commit_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/pfam_dpath.sv =====
// ----------------------------------------------------------------------------
// pfam_dpath
// Frame bitmap, free count, directory entry memory and result register.
// ----------------------------------------------------------------------------
module pfam_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfam_pkg::dp_cmd_t    cmd_i,
  output pfam_pkg::dp_status_t status_o,
  input  pfam_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pfam_pkg::out_item_t  out_item_o
);

  // Directory entry memory
  logic [pfam_pkg::ENTRY_W-1:0] mem_q [pfam_pkg::MEM_DEPTH];
  logic [pfam_pkg::ENTRY_W-1:0] rd_data_q;
  logic                         mem_we;
  logic [pfam_pkg::MEM_AW-1:0]  mem_waddr;
  logic [pfam_pkg::ENTRY_W-1:0] mem_wdata;
  logic [pfam_pkg::MEM_AW-1:0]  in_addr;
  logic [pfam_pkg::MEM_AW-1:0]  req_addr;

  // Clearing pass
  logic [pfam_pkg::MEM_AW-1:0]  clr_addr_q;
  logic [pfam_pkg::PAGE_W-1:0]  clr_page;
  logic [pfam_pkg::ENTRY_W-1:0] clr_data;

  // Allocator state
  logic [pfam_pkg::FRAME_COUNT-1:0] frame_used_q, frame_used_d;
  logic [pfam_pkg::COUNT_W-1:0]     free_count_q, free_count_d;

  // Held request
  pfam_pkg::in_item_t req_q;

  // Lowest-free search
  logic [pfam_pkg::GROUP_COUNT-1:0] grp_free_d, grp_free_q;
  logic [pfam_pkg::IN_GROUP_W-1:0]  grp_low_d [pfam_pkg::GROUP_COUNT];
  logic [pfam_pkg::IN_GROUP_W-1:0]  grp_low_q [pfam_pkg::GROUP_COUNT];
  logic [pfam_pkg::GROUP_W-1:0]     grp_bits;
  logic                             alloc_found;
  logic [pfam_pkg::GROUP_SEL_W-1:0] alloc_grp;
  logic [pfam_pkg::FRAME_W-1:0]     alloc_frame;

  // Decision
  logic                           dir_ok;
  logic                           ent_present;
  logic [pfam_pkg::PFN_W-1:0]     ent_pfn;
  logic                           pfn_in_range;
  logic [pfam_pkg::FRAME_W-1:0]   pfn_frame;
  logic [pfam_pkg::CMP_W-1:0]     avail;
  logic                           res_ok;
  logic                           res_change;
  logic [pfam_pkg::FRAME_W-1:0]   res_frame;
  logic [pfam_pkg::ENTRY_W-1:0]   res_entry;

  // Result register
  logic                out_valid_q, out_valid_d;
  pfam_pkg::out_item_t out_item_q;

  // Memory addresses: directory-major, page in the low bits
  assign in_addr  = pfam_pkg::MEM_AW'(32'(in_item_i.dir_id) * pfam_pkg::ENTRIES_PER_DIR
                                      + 32'(in_item_i.virtual_page));
  assign req_addr = pfam_pkg::MEM_AW'(32'(req_q.dir_id) * pfam_pkg::ENTRIES_PER_DIR
                                      + 32'(req_q.virtual_page));

  // Kernel template for the clearing pass
  assign clr_page = clr_addr_q[pfam_pkg::PAGE_W-1:0];
  assign clr_data = (clr_page == '0 || clr_page == pfam_pkg::KERNEL_HIGH_INDEX)
                    ? pfam_pkg::KERNEL_ENTRY : '0;

  assign status_o.clear_last = (clr_addr_q == pfam_pkg::MEM_AW'(pfam_pkg::MEM_DEPTH - 1));
  assign status_o.out_stall  = out_valid_q && !out_ready_i;

  // Advance the clearing address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_addr_q <= clr_addr_q + pfam_pkg::MEM_AW'(1);
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      req_q <= in_item_i;
    end
  end

  // Per-group free flag and lowest free index
  always_comb begin
    for (int g = 0; g < pfam_pkg::GROUP_COUNT; g++) begin
      grp_bits      = ~frame_used_q[g*pfam_pkg::GROUP_W +: pfam_pkg::GROUP_W];
      grp_free_d[g] = |grp_bits;
      grp_low_d[g]  = '0;
      for (int b = pfam_pkg::GROUP_W - 1; b >= 0; b--) begin
        if (grp_bits[b]) begin
          grp_low_d[g] = pfam_pkg::IN_GROUP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      grp_free_q <= grp_free_d;
      grp_low_q  <= grp_low_d;
    end
  end

  // Pick the lowest group that has a free frame
  always_comb begin
    alloc_found = |grp_free_q;
    alloc_grp   = '0;
    for (int g = pfam_pkg::GROUP_COUNT - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        alloc_grp = pfam_pkg::GROUP_SEL_W'(g);
      end
    end
    alloc_frame = pfam_pkg::FRAME_W'(32'(alloc_grp) * pfam_pkg::GROUP_W
                                     + 32'(grp_low_q[alloc_grp]));
  end

  // Decide the outcome of the held request
  assign dir_ok       = 32'(req_q.dir_id) < pfam_pkg::DIR_COUNT;
  assign ent_present  = rd_data_q[0];
  assign ent_pfn      = rd_data_q[pfam_pkg::ENTRY_W-1:pfam_pkg::FLAGS_W];
  assign pfn_in_range = 32'(ent_pfn) < pfam_pkg::FRAME_COUNT;
  assign pfn_frame    = ent_pfn[pfam_pkg::FRAME_W-1:0];
  assign avail        = pfam_pkg::CMP_W'({free_count_q, {pfam_pkg::FRAME_SIZE_LOG2{1'b0}}});

  always_comb begin
    res_ok       = 1'b0;
    res_change   = 1'b0;
    res_frame    = '0;
    res_entry    = '0;
    frame_used_d = frame_used_q;
    free_count_d = free_count_q;
    case (pfam_pkg::opcode_e'(req_q.opcode))
      pfam_pkg::OP_CHECK: begin
        res_ok = (avail >= pfam_pkg::CMP_W'(req_q.amount));
      end
      pfam_pkg::OP_ALLOC: begin
        if (dir_ok && alloc_found) begin
          res_ok                    = 1'b1;
          res_change                = 1'b1;
          res_frame                 = alloc_frame;
          res_entry                 = {pfam_pkg::PFN_W'(alloc_frame),
                                       pfam_pkg::PTE_BIG | pfam_pkg::PTE_USER |
                                       pfam_pkg::PTE_WRITE | pfam_pkg::PTE_PRESENT};
          frame_used_d[alloc_frame] = 1'b1;
          free_count_d              = free_count_q - pfam_pkg::COUNT_W'(1);
        end
      end
      pfam_pkg::OP_FREE: begin
        if (dir_ok && ent_present && pfn_in_range && frame_used_q[pfn_frame]) begin
          res_ok                  = 1'b1;
          res_change              = 1'b1;
          res_frame               = pfn_frame;
          res_entry               = '0;
          frame_used_d[pfn_frame] = 1'b0;
          free_count_d            = free_count_q + pfam_pkg::COUNT_W'(1);
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Update the bitmap and the free count on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_used_q <= pfam_pkg::FRAME_COUNT'(1);
      free_count_q <= pfam_pkg::COUNT_W'(pfam_pkg::FRAME_COUNT - 1);
    end else if (cmd_i.commit_en) begin
      frame_used_q <= frame_used_d;
      free_count_q <= free_count_d;
    end
  end

  // One write port shared by the clearing pass and the commit
  assign mem_we    = cmd_i.clear_en || (cmd_i.commit_en && res_change);
  assign mem_waddr = cmd_i.clear_en ? clr_addr_q : req_addr;
  assign mem_wdata = cmd_i.clear_en ? clr_data : res_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.load_en) begin
      rd_data_q <= mem_q[in_addr];
    end
  end

  // Result register: load on commit, drop when taken
  always_comb begin
    if (cmd_i.commit_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_en) begin
      out_item_q.ok          <= res_ok;
      out_item_q.frame       <= res_frame;
      out_item_q.free_frames <= free_count_d;
      out_item_q.flush_valid <= res_change;
      out_item_q.flush_page  <= res_change ? req_q.virtual_page : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hw/rtl/page_frame_allocator_mapper.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_mapper
// Bitmap allocator of 4 MB frames with per-directory 4 MB page mappings.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with in_item_i (opcode, dir_id,
//   virtual_page, amount). Each request yields exactly one result on
//   out_valid_o/out_ready_i with out_item_o (ok, frame, free_frames,
//   flush_valid, flush_page); flush_valid asks the core to invalidate the
//   TLB entry of flush_page.
//   Sequencing: one request is in flight at a time, so a new request is
//   taken only after the last one commits. Its steps are directory memory
//   read, group-wise lowest-free search, commit.
//   Reset: the bitmap marks frame 0 used and the free count is 31 at once;
//   the directory memory is then swept one entry per cycle to load the
//   kernel template into all 4096 entries; in_ready_o is low throughout.
//   Receiver stall: the result register holds its item. The next request
//   is still accepted and looked up, then waits at commit until the held
//   result is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfam_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfam_pkg::out_item_t out_item_o
);

  pfam_pkg::dp_cmd_t    cmd;
  pfam_pkg::dp_status_t status;

  // Sequencer
  pfam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  pfam_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // One request at a time: no back-to-back acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Free count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_item_o.free_frames) <= pfam_pkg::FRAME_COUNT))
    else $error("free frame count out of range");

  // A failed request carries no frame and no flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.ok) |->
      (!out_item_o.flush_valid && out_item_o.frame == '0 && out_item_o.flush_page == '0))
    else $error("failed request reports a frame or flush");

  // Commit never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit_en |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule
